[src/prefix_table_substring_search_unit_macros.svh]
// Assertion macros for the prefix table substring search unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PREFIX_TABLE_SUBSTRING_SEARCH_UNIT_MACROS_SVH
`define PREFIX_TABLE_SUBSTRING_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define PFXS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfxs: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define PFXS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfxs: next-cycle check failed");

`endif

[src/pfxs_pkg.sv]
// Package for the prefix table substring search unit: sizes, command codes,
// payload structs and the control/status structs of the matcher cells.
// Depends on nothing.
package pfxs_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int CHAR_BITS     = 21;
    localparam int POSITION_BITS = 32;
    localparam int CH_WIDTH      = 21;
    localparam int USED_BITS     = (CHAR_BITS < CH_WIDTH) ? CHAR_BITS : CH_WIDTH;
    localparam int COUNT_BITS    = $clog2(MAX_PATTERN + 1);

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [CH_WIDTH-1:0] ch;
    } t_in_item;

    typedef struct packed {
        logic                     match;
        logic [POSITION_BITS-1:0] start_position;
        logic                     overflow;
        logic [COUNT_BITS-1:0]    pattern_length;
    } t_out_item;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic                 append;
        logic                 text;
        logic                 clear_match;
        logic                 clear_pattern;
        logic [USED_BITS-1:0] ch;
    } t_cell_ctl;

    // What one cell shows its neighbors and the control logic.
    typedef struct packed {
        logic active;
        logic loaded;
        logic end_hit;
    } t_cell_stat;

endpackage

[src/prefix_table_substring_search_unit.sv]
// Top level of the prefix table substring search unit: command decode,
// the row of matcher cells, counters and the registered result stage.
// Depends on pfxs_pkg, pfxs_cell and the assertion macro header.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | into unit | i_in_valid / o_in_ready  | pfxs_pkg::t_in_item
//  out     | out of it | o_out_valid / i_out_ready| pfxs_pkg::t_out_item
//
// Each input transaction gives exactly one result transaction, held in the
// output register; a new one is taken every cycle unless the output stalls:
// cells compare in parallel, so the single output register sets the pace.
// Reset is synchronous and active low; it empties the pattern and clears the
// match state and text position. When the output is stalled, the result
// register holds and the input stops accepting until the result is taken.
`include "prefix_table_substring_search_unit_macros.svh"

module prefix_table_substring_search_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pfxs_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pfxs_pkg::t_out_item  o_out
);

    localparam int NCELL = pfxs_pkg::MAX_PATTERN;
    localparam int PW    = pfxs_pkg::POSITION_BITS;
    localparam int CW    = pfxs_pkg::COUNT_BITS;

    logic                  w_accept;
    pfxs_pkg::t_cell_ctl   w_ctl;
    pfxs_pkg::t_cell_stat  w_stat [NCELL];
    logic [NCELL-1:0]      w_active;
    logic [NCELL-1:0]      w_loaded;
    logic [NCELL-1:0]      w_end_hit;
    logic                  w_match;
    logic                  w_full;
    logic [PW-1:0]         w_back;
    logic [PW-1:0]         w_start;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [PW-1:0]         r_pos;
    logic [PW-1:0]         n_pos;
    logic                  r_out_valid;
    logic                  n_out_valid;
    pfxs_pkg::t_out_item   r_out;
    pfxs_pkg::t_out_item   n_out;

    // The input is taken whenever the result register is free or is being
    // emptied in the same cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ctl.append        = w_accept && (i_in.cmd == pfxs_pkg::CMD_APPEND);
    assign w_ctl.text          = w_accept && (i_in.cmd == pfxs_pkg::CMD_TEXT);
    assign w_ctl.clear_match   = w_accept && ((i_in.cmd == pfxs_pkg::CMD_RESTART) ||
                                              (i_in.cmd == pfxs_pkg::CMD_CLEAR));
    assign w_ctl.clear_pattern = w_accept && (i_in.cmd == pfxs_pkg::CMD_CLEAR);
    assign w_ctl.ch            = i_in.ch[pfxs_pkg::USED_BITS-1:0];

    // The row of cells. Cell k holds pattern character k and remembers
    // whether the last k+1 text characters equal the first k+1 pattern
    // characters. The loaded flags form a thermometer code, so the first
    // empty cell takes the next appended character, and a cell whose right
    // neighbor is empty is the last one of the pattern: its hit is a match.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        logic w_prev_active;
        logic w_prev_loaded;
        logic w_next_loaded;

        if (k == 0) begin : g_first
            assign w_prev_active = 1'b1;
            assign w_prev_loaded = 1'b1;
        end else begin : g_inner
            assign w_prev_active = w_active[k-1];
            assign w_prev_loaded = w_loaded[k-1];
        end

        if (k == NCELL - 1) begin : g_last
            assign w_next_loaded = 1'b0;
        end else begin : g_more
            assign w_next_loaded = w_loaded[k+1];
        end

        pfxs_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_prev_active (w_prev_active),
            .i_prev_loaded (w_prev_loaded),
            .i_next_loaded (w_next_loaded),
            .o_stat        (w_stat[k])
        );

        assign w_active[k]  = w_stat[k].active;
        assign w_loaded[k]  = w_stat[k].loaded;
        assign w_end_hit[k] = w_stat[k].end_hit;
    end

    // At most one cell is the last of the pattern, so an OR picks its hit.
    assign w_match = w_ctl.text && (|w_end_hit);
    assign w_full  = (r_count == CW'(NCELL));

    // An occurrence of length r_count ends at r_pos; the start saturates at
    // zero when r_pos is below r_count - 1.
    assign w_back  = PW'(r_count - CW'(1));
    assign w_start = (r_pos >= w_back) ? (r_pos - w_back) : '0;

    always_comb begin
        n_count = r_count;
        if (w_ctl.clear_pattern) begin
            n_count = '0;
        end else if (w_ctl.append && !w_full) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (w_accept && (i_in.cmd == pfxs_pkg::CMD_RESTART)) begin
            n_pos = '0;
        end else if (w_ctl.text && (r_pos != '1)) begin
            n_pos = r_pos + PW'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_out.match          = w_match;
        n_out.start_position = w_match ? w_start : '0;
        n_out.overflow       = w_ctl.append && w_full;
        n_out.pattern_length = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The loaded flags always agree with the pattern length counter.
    `PFXS_ASSERT_NOW(a_count_matches_cells, i_clk, i_rst_n, 1'b1,
        $countones(w_loaded) == r_count)
    // Prefix-match bits live only inside the loaded pattern.
    `PFXS_ASSERT_NOW(a_active_within_pattern, i_clk, i_rst_n, 1'b1,
        (w_active & ~w_loaded) == '0)
    // A reported match needs a non-empty pattern.
    `PFXS_ASSERT_NOW(a_match_needs_pattern, i_clk, i_rst_n, r_out_valid && r_out.match,
        r_out.pattern_length != '0)
    // A refused append only happens against a full store.
    `PFXS_ASSERT_NOW(a_overflow_only_full, i_clk, i_rst_n, r_out_valid && r_out.overflow,
        r_out.pattern_length == CW'(NCELL))
    // Clearing the pattern empties every cell and the match state.
    `PFXS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_ctl.clear_pattern,
        (w_loaded == '0) && (w_active == '0))

endmodule

[src/pfxs_cell.sv]
// One matcher cell: holds one pattern character, its loaded flag and the
// prefix-match bit for the prefix that ends at this character.
// Depends on pfxs_pkg.
module pfxs_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfxs_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_prev_active,
    input  logic                  i_prev_loaded,
    input  logic                  i_next_loaded,
    output pfxs_pkg::t_cell_stat  o_stat
);

    logic [pfxs_pkg::USED_BITS-1:0] r_char;
    logic                           r_loaded;
    logic                           r_active;
    logic                           n_loaded;
    logic                           n_active;
    logic                           w_hit;
    logic                           w_take;

    // The text character extends the prefix held by the left neighbor.
    assign w_hit  = r_loaded && i_prev_active && (i_ctl.ch == r_char);
    // The first empty cell takes an appended character.
    assign w_take = i_ctl.append && !r_loaded && i_prev_loaded;

    always_comb begin
        n_loaded = r_loaded;
        if (i_ctl.clear_pattern) begin
            n_loaded = 1'b0;
        end else if (w_take) begin
            n_loaded = 1'b1;
        end
    end

    // A full match is not kept: the state falls back to the longest border.
    always_comb begin
        n_active = r_active;
        if (i_ctl.clear_match) begin
            n_active = 1'b0;
        end else if (i_ctl.text) begin
            n_active = w_hit && i_next_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_loaded <= n_loaded;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char <= i_ctl.ch;
        end
    end

    assign o_stat.active  = r_active;
    assign o_stat.loaded  = r_loaded;
    assign o_stat.end_hit = w_hit && !i_next_loaded;

endmodule
